// File: sv/frld_pkg.sv
package frld_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 16;
    localparam int SUM_W    = 47;
    localparam int LEVEL_W  = 16;
    localparam int FRAC_W   = 16;
    localparam int EXP_W    = 6;
    localparam int LOG_W    = EXP_W + FRAC_W;
    localparam int OPA_W    = 31;
    localparam int OPB_W    = 32;
    localparam int PROD_W   = 64;
    localparam int STEP_W   = 5;

    localparam logic [LEN_W-1:0]   LEN_RESET       = 16'd2000;
    // 10*log10(2) in Q24
    localparam logic [OPA_W-1:0]   DB_PER_LOG2_Q24 = 31'd50504453;
    localparam logic [STEP_W-1:0]  SQR_STEPS       = 5'd8;
    localparam logic [STEP_W-1:0]  LOG_STEPS       = 5'd16;
    localparam logic [STEP_W-1:0]  K_STEPS         = 5'd11;
    localparam logic [STEP_W-1:0]  LOG_ROUNDS      = 5'd16;
    localparam logic [EXP_W-1:0]   EXP_TOP         = 6'd46;
    localparam logic [LEVEL_W-1:0] LEVEL_SILENT    = 16'h8000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [LEN_W-1:0]           len_t;
    typedef logic signed [LEVEL_W-1:0]  level_t;
    typedef logic [SUM_W-1:0]           sum_t;
    typedef logic [LOG_W-1:0]           log_t;

endpackage

// File: sv/fragment_rms_level_db_core.sv
// Fragment RMS level meter.
// Input channel (in_valid/in_ready): one signed 16-bit sample per transfer,
// with end_of_stream marking the last sample of a stream; a partial
// fragment is dropped after it. Output channel (out_valid/out_ready): one
// level per completed fragment, signed Q7.8 dB relative to one sample LSB,
// with silent set and level_db = -32768 for an all-zero fragment.
// cfg_we/cfg_wdata write the fragment length (0 acts as 1); the user is
// to write it only while idle, as the block does not enforce this. Each
// sample passes a radix-4 serial squarer that feeds a 47-bit accumulator.
// At a fragment end the same serial multiplier computes log2 of the sum
// and of the count: a bit-serial normalize, then 16 squaring rounds, per
// operand; the dB scaling also runs on that multiplier.
// The output register holds a finished level while the receiver stalls;
// samples are still taken meanwhile, and the block waits only when a new
// level is ready and the old one has not been taken.
// Reset clears the sum and count, drops any pending result and sets the
// fragment length to 2000.
module fragment_rms_level_db_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  frld_pkg::len_t    cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  frld_pkg::sample_t sample,
    input  logic              end_of_stream,
    output logic              out_valid,
    input  logic              out_ready,
    output frld_pkg::level_t  level_db,
    output logic              silent
);
    import frld_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQR  = 4'd1;
    localparam logic [3:0] S_ACC  = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_NORM = 4'd4;
    localparam logic [3:0] S_LSQ  = 4'd5;
    localparam logic [3:0] S_LUPD = 4'd6;
    localparam logic [3:0] S_KMUL = 4'd7;
    localparam logic [3:0] S_RND  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]         state_reg, state_next;
    logic [LEN_W-1:0]   spf_reg;
    sum_t               sum_reg, sum_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic               eos_reg, eos_next;
    logic               out_valid_reg, out_valid_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [STEP_W-1:0]  round_reg, round_next;
    logic               which_reg, which_next;

    logic [OPA_W-1:0]   a_reg, a_next;
    logic [OPB_W-1:0]   b_reg, b_next;
    logic [PROD_W-1:0]  p_reg, p_next;
    sum_t               n_reg, n_next;
    logic [EXP_W-1:0]   e_reg, e_next;
    logic [FRAC_W-1:0]  frac_reg, frac_next;
    log_t               logs_reg, logs_next;
    logic               neg_reg, neg_next;
    level_t             res_level_reg, res_level_next;
    logic               res_silent_reg, res_silent_next;
    level_t             level_reg, level_next;
    logic               silent_reg, silent_next;

    logic [SAMPLE_W-1:0] mag;
    logic [OPA_W+1:0]    pp;
    logic [PROD_W-1:0]   p_step;
    logic [LEN_W-1:0]    len;
    logic [OPB_W-1:0]    mm;
    logic                fbit;
    logic [OPA_W-1:0]    m_new;
    logic [FRAC_W-1:0]   frac_new;
    log_t                log_cur;
    logic [LOG_W:0]      d;
    log_t                dmag;
    logic [48:0]         rsum;
    logic [16:0]         q;
    logic [14:0]         qc;
    logic                out_free;

    assign mag      = sample[SAMPLE_W-1] ? SAMPLE_W'(~sample + 1'b1) : SAMPLE_W'(sample);
    assign len      = (spf_reg == '0) ? LEN_W'(1) : spf_reg;
    assign out_free = !out_valid_reg || out_ready;

    // radix-4 digit times multiplicand, MSB first
    always_comb
    begin
        case (b_reg[OPB_W-1:OPB_W-2])
            2'd0:    pp = '0;
            2'd1:    pp = {2'b00, a_reg};
            2'd2:    pp = {1'b0, a_reg, 1'b0};
            2'd3:    pp = {2'b00, a_reg} + {1'b0, a_reg, 1'b0};
            default: pp = '0;
        endcase
    end

    assign p_step   = {p_reg[PROD_W-3:0], 2'b00} + PROD_W'(pp);

    assign mm       = p_reg[61:30];
    assign fbit     = mm[OPB_W-1];
    assign m_new    = fbit ? mm[OPB_W-1:1] : mm[OPA_W-1:0];
    assign frac_new = {frac_reg[FRAC_W-2:0], fbit};
    assign log_cur  = {e_reg, frac_new};
    assign d        = {1'b0, logs_reg} - {1'b0, log_cur};
    assign dmag     = d[LOG_W] ? LOG_W'(~d + 1'b1) : d[LOG_W-1:0];

    assign rsum     = {1'b0, p_reg[47:0]} + 49'h0_0000_8000_0000;
    assign q        = rsum[48:32];
    assign qc       = (q > 17'd32767) ? 15'h7FFF : q[14:0];

    always_comb
    begin
        state_next      = state_reg;
        sum_next        = sum_reg;
        cnt_next        = cnt_reg;
        eos_next        = eos_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        step_next       = step_reg;
        round_next      = round_reg;
        which_next      = which_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        p_next          = p_reg;
        n_next          = n_reg;
        e_next          = e_reg;
        frac_next       = frac_reg;
        logs_next       = logs_reg;
        neg_next        = neg_reg;
        res_level_next  = res_level_reg;
        res_silent_next = res_silent_reg;
        level_next      = level_reg;
        silent_next     = silent_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    eos_next   = end_of_stream;
                    a_next     = OPA_W'(mag);
                    b_next     = {mag, {(OPB_W-SAMPLE_W){1'b0}}};
                    p_next     = '0;
                    step_next  = SQR_STEPS;
                    state_next = S_SQR;
                end
            end
            S_SQR, S_LSQ, S_KMUL:
            begin
                p_next    = p_step;
                b_next    = {b_reg[OPB_W-3:0], 2'b00};
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    case (state_reg)
                        S_SQR:   state_next = S_ACC;
                        S_LSQ:   state_next = S_LUPD;
                        default: state_next = S_RND;
                    endcase
                end
            end
            S_ACC:
            begin
                sum_next   = sum_reg + p_reg[SUM_W-1:0];
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (cnt_reg >= len)
                begin
                    if (sum_reg == '0)
                    begin
                        res_level_next  = LEVEL_SILENT;
                        res_silent_next = 1'b1;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        n_next     = sum_reg;
                        e_next     = EXP_TOP;
                        which_next = 1'b0;
                        state_next = S_NORM;
                    end
                end
                else
                begin
                    if (eos_reg)
                    begin
                        sum_next = '0;
                        cnt_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_NORM:
            begin
                if (n_reg[SUM_W-1])
                begin
                    a_next     = n_reg[SUM_W-1:SUM_W-OPA_W];
                    b_next     = {1'b0, n_reg[SUM_W-1:SUM_W-OPA_W]};
                    p_next     = '0;
                    step_next  = LOG_STEPS;
                    round_next = LOG_ROUNDS;
                    frac_next  = '0;
                    state_next = S_LSQ;
                end
                else
                begin
                    n_next = {n_reg[SUM_W-2:0], 1'b0};
                    e_next = e_reg - 1'b1;
                end
            end
            S_LUPD:
            begin
                frac_next = frac_new;
                if (round_reg == STEP_W'(1))
                begin
                    if (!which_reg)
                    begin
                        logs_next  = log_cur;
                        n_next     = SUM_W'(cnt_reg);
                        e_next     = EXP_TOP;
                        which_next = 1'b1;
                        state_next = S_NORM;
                    end
                    else
                    begin
                        neg_next   = d[LOG_W];
                        a_next     = DB_PER_LOG2_Q24;
                        b_next     = {dmag, {(OPB_W-LOG_W){1'b0}}};
                        p_next     = '0;
                        step_next  = K_STEPS;
                        state_next = S_KMUL;
                    end
                end
                else
                begin
                    round_next = round_reg - 1'b1;
                    a_next     = m_new;
                    b_next     = {1'b0, m_new};
                    p_next     = '0;
                    step_next  = LOG_STEPS;
                    state_next = S_LSQ;
                end
            end
            S_RND:
            begin
                res_level_next  = neg_reg ? LEVEL_W'(~{1'b0, qc} + 1'b1) : LEVEL_W'({1'b0, qc});
                res_silent_next = 1'b0;
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    level_next     = res_level_reg;
                    silent_next    = res_silent_reg;
                    out_valid_next = 1'b1;
                    sum_next       = '0;
                    cnt_next       = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            spf_reg       <= LEN_RESET;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            eos_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            round_reg     <= '0;
            which_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                spf_reg <= cfg_wdata;
            end
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            eos_reg       <= eos_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            round_reg     <= round_next;
            which_reg     <= which_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        p_reg          <= p_next;
        n_reg          <= n_next;
        e_reg          <= e_next;
        frac_reg       <= frac_next;
        logs_reg       <= logs_next;
        neg_reg        <= neg_next;
        res_level_reg  <= res_level_next;
        res_silent_reg <= res_silent_next;
        level_reg      <= level_next;
        silent_reg     <= silent_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign level_db  = level_reg;
    assign silent    = silent_reg;

    a_silent_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && silent) |-> (level_db == LEVEL_SILENT))
        else $error("silent result without minimum code");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second sample taken while squaring");

    a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free) |=>
            (out_valid && sum_reg == '0 && cnt_reg == '0))
        else $error("fragment state not cleared on result");

    a_log_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LSQ) |-> a_reg[OPA_W-1])
        else $error("log mantissa lost normalization");

endmodule

// File: bench/tb_fragment_rms_level_db_core.sv
module tb_fragment_rms_level_db_core;
    timeunit 1ns;
    timeprecision 1ps;

    import frld_pkg::*;

    localparam int IDLE_PCT     = 37;
    localparam int SETTLE_CYC   = 800;
    localparam int HOLD_CYC     = 3000;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int PHASE_ITEMS  = 75;

    typedef struct {
        level_t level;
        logic   silent;
    } level_result_t;

    class level_checker;
        localparam logic [63:0] DB_PER_OCTAVE_Q24 = 64'd50504453;
        localparam int          LOG_FRAC          = 16;

        len_t            frag_len;
        sum_t            energy;
        len_t            count;
        level_result_t   pending_levels[$];
        int              errors;

        function new();
            frag_len = 16'd2000;
            energy   = '0;
            count    = '0;
            errors   = 0;
        endfunction

        function void set_length(len_t v);
            frag_len = v;
        endfunction

        function int pending();
            return pending_levels.size();
        endfunction

        function longint log2_fixed(logic [63:0] x);
            int unsigned e;
            logic [63:0] m;
            logic [63:0] frac;
            e = 0;
            frac = '0;
            while (e < 63 && (x >> (e + 1)) != 0)
                e++;
            if (e <= 30)
                m = x << (30 - e);
            else
                m = x >> (e - 30);
            for (int i = 0; i < LOG_FRAC; i++)
            begin
                m = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (64'd2 << 30))
                begin
                    frac = frac | 64'd1;
                    m = m >> 1;
                end
            end
            return longint'((64'(e) << LOG_FRAC) | frac);
        endfunction

        function level_t predict_level(sum_t sum, len_t n);
            longint      d;
            longint      v;
            logic [63:0] mag;
            logic [63:0] q;
            d = log2_fixed(64'(sum)) - log2_fixed(64'(n));
            mag = (d < 0) ? 64'(-d) : 64'(d);
            mag = mag * DB_PER_OCTAVE_Q24;
            q = (mag + (64'd1 << 31)) >> 32;
            if (q > 64'd32767)
                q = 64'd32767;
            v = (d < 0) ? -longint'(q) : longint'(q);
            return level_t'(v[15:0]);
        endfunction

        function void note_sample(sample_t s, logic eos);
            longint        sv;
            longint        mag;
            len_t          eff_len;
            level_result_t r;
            sv = longint'(s);
            mag = (sv < 0) ? -sv : sv;
            eff_len = (frag_len == 0) ? len_t'(1) : frag_len;
            energy = energy + sum_t'(mag * mag);
            count = count + len_t'(1);
            if (count >= eff_len)
            begin
                if (energy == 0)
                begin
                    r.level  = LEVEL_SILENT;
                    r.silent = 1'b1;
                end
                else
                begin
                    r.level  = predict_level(energy, count);
                    r.silent = 1'b0;
                end
                pending_levels.push_back(r);
                energy = '0;
                count  = '0;
            end
            if (eos)
            begin
                energy = '0;
                count  = '0;
            end
        endfunction

        function void check_level(level_t lvl, logic sil);
            level_result_t r;
            if (pending_levels.size() == 0)
            begin
                $display("%0t: unexpected level transfer, actual level_db %h silent %b",
                         $time, lvl, sil);
                errors++;
                return;
            end
            r = pending_levels.pop_front();
            if (lvl !== r.level)
            begin
                $display("%0t: level_db mismatch, expected %h actual %h",
                         $time, r.level, lvl);
                errors++;
            end
            if (sil !== r.silent)
            begin
                $display("%0t: silent mismatch, expected %b actual %b",
                         $time, r.silent, sil);
                errors++;
            end
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n;
    logic    cfg_we;
    len_t    cfg_wdata;
    logic    in_valid;
    logic    in_ready;
    sample_t sample;
    logic    end_of_stream;
    logic    out_valid;
    logic    out_ready;
    level_t  level_db;
    logic    silent;

    logic    quiet;
    int      hold_token;
    int      hold_seen;
    int      cycles = 0;

    level_checker book;

    fragment_rms_level_db_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .level_db      (level_db),
        .silent        (silent)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random backpressure, plus a long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_token)
            begin
                hold_seen = hold_token;
                out_ready <= 1'b0;
                repeat (HOLD_CYC) @(posedge clk);
            end
            out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            book.check_level(level_db, silent);
    end

    task automatic push_sample(sample_t s, logic eos);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        sample        <= s;
        end_of_stream <= eos;
        do
            @(posedge clk);
        while (!in_ready);
        book.note_sample(s, eos);
    endtask

    task automatic wait_drained();
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_length(len_t v);
        in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYC) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        book.set_length(v);
    endtask

    function automatic sample_t pick_sample(int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct)
            return sample_t'(0);
        if (r < zero_pct + 20)
            return sample_t'(int'($urandom_range(0, 31)) - 16);
        return sample_t'($urandom_range(0, 65535));
    endfunction

    initial
    begin
        len_t phase_len;
        int   zero_pct;
        book          = new();
        quiet         = 1'b0;
        hold_token    = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        sample        = '0;
        end_of_stream = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset length, partial fragment dropped by end of stream
        push_sample(16'sd100, 1'b0);
        push_sample(-16'sd5, 1'b1);

        write_length(16'd1);
        push_sample(16'sd0, 1'b0);
        push_sample(16'sd32767, 1'b0);
        push_sample(-16'sd32768, 1'b0);
        push_sample(16'sd1, 1'b0);
        push_sample(-16'sd1, 1'b1);

        // zero length behaves as one
        write_length(16'd0);
        push_sample(-16'sd1234, 1'b0);
        push_sample(16'sd7, 1'b0);

        write_length(16'd3);
        push_sample(16'sd1, 1'b0);
        push_sample(16'sd0, 1'b1);
        push_sample(16'sd0, 1'b0);
        push_sample(16'sd0, 1'b0);
        push_sample(16'sd0, 1'b0);

        // length lowered mid-fragment
        write_length(16'd65535);
        repeat (4) push_sample(pick_sample(0), 1'b0);
        write_length(16'd2);
        push_sample(16'sd3, 1'b0);

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: phase_len = 16'd1;
                1: phase_len = 16'd2;
                2: phase_len = len_t'($urandom_range(3, 8));
                3: phase_len = 16'd16;
                4: phase_len = len_t'($urandom_range(1, 32));
                5: phase_len = 16'd4;
                6: phase_len = 16'd0;
                default: phase_len = len_t'($urandom_range(9, 40));
            endcase
            zero_pct = (p == 5) ? 60 : 5;
            write_length(phase_len);
            quiet <= (p == 5);
            if (p == 0)
                hold_token <= hold_token + 1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 2 && i == 40)
                begin
                    in_valid <= 1'b0;
                    wait_drained();
                    @(posedge clk);
                end
                push_sample(pick_sample(zero_pct), $urandom_range(0, 99) < 4);
            end
        end

        in_valid <= 1'b0;
        quiet    <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYC) @(posedge clk);
        if (book.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
